@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/core/trm_pkg.sv @@
package trm_pkg;

    typedef enum logic [2:0] {
        ACT_ISSUE    = 3'd0,
        ACT_RESPONSE = 3'd1,
        ACT_REGISTER = 3'd2,
        ACT_CANCEL   = 3'd3,
        ACT_WAIT     = 3'd4,
        ACT_TICK     = 3'd5,
        ACT_CLEAR    = 3'd6,
        ACT_UNUSED   = 3'd7
    } t_action;

    typedef enum logic [3:0] {
        ST_ISSUED     = 4'd0,
        ST_IGNORED    = 4'd1,
        ST_RESOLVED   = 4'd2,
        ST_FIRED      = 4'd3,
        ST_STASHED    = 4'd4,
        ST_STASH_DROP = 4'd5,
        ST_REGISTERED = 4'd6,
        ST_NO_SLOT    = 4'd7,
        ST_CANCELLED  = 4'd8,
        ST_STASH_HIT  = 4'd9,
        ST_WAITING    = 4'd10,
        ST_TIMEOUT    = 4'd11,
        ST_TICK_IDLE  = 4'd12,
        ST_CLEARED    = 4'd13
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC
    } t_fsm;

    localparam int TIMEOUT_W = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0] TAG_LAST = 8'd255;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

@@ rtl/core/tag_response_matcher.sv @@
// Tag scoreboard: issues tags 1..255, matches responses to a blocking wait,
// one-shot async slots, or a stash. Each item passes through the controller as
// a capture step, then an execute step against the slot and stash tables; busy
// is high in the execute step, and the result appears in the cycle after it with
// o_done high for exactly one cycle. The receiver cannot stall, so results
// must be taken when o_done is high. A new start is ignored while busy is high.
`include "assert_macros.svh"

module tag_response_matcher #(
    parameter int PENDING_SLOTS = 8,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_tag,
    input  logic [31:0] i_result_data,
    output logic        o_done,
    output logic [3:0]  o_status,
    output logic [7:0]  o_tag_out,
    output logic [31:0] o_payload_out,
    output logic [2:0]  o_slot_out
);

    trm_pkg::t_cmd cmd;

    trm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    trm_datapath #(
        .PENDING_SLOTS (PENDING_SLOTS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_tag          (i_tag),
        .i_result_data  (i_result_data),
        .o_result_valid (o_done),
        .o_status       (o_status),
        .o_tag_out      (o_tag_out),
        .o_payload_out  (o_payload_out),
        .o_slot_out     (o_slot_out)
    );

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_busy_done, i_clk, i_rst_n, busy, o_done)
    `ASSERT_IMPLIES(a_done_free, i_clk, i_rst_n, o_done, !busy)

endmodule

@@ rtl/core/trm_ctrl.sv @@
module trm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output trm_pkg::t_cmd o_cmd
);

    trm_pkg::t_fsm r_state;
    trm_pkg::t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trm_pkg::FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        o_busy        = 1'b0;
        case (r_state)
            trm_pkg::FSM_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = trm_pkg::FSM_EXEC;
                end
            end
            trm_pkg::FSM_EXEC: begin
                o_busy        = 1'b1;
                o_cmd.execute = 1'b1;
                n_state       = trm_pkg::FSM_IDLE;
            end
            default: begin
                n_state = trm_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/trm_datapath.sv @@
module trm_datapath #(
    parameter int PENDING_SLOTS = 8,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  trm_pkg::t_cmd        i_cmd,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  logic [2:0]           i_action,
    input  logic [7:0]           i_tag,
    input  logic [31:0]          i_result_data,
    output logic                 o_result_valid,
    output logic [3:0]           o_status,
    output logic [7:0]           o_tag_out,
    output logic [31:0]          o_payload_out,
    output logic [2:0]           o_slot_out
);

    localparam int SW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int PW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

    logic [15:0]              r_timeout;
    logic [7:0]               r_counter;
    logic [7:0]               r_wait_tag;
    logic [15:0]              r_elapsed;
    logic [PENDING_SLOTS-1:0] r_slot_act;
    logic [7:0]               r_slot_tag [PENDING_SLOTS];
    logic [PENDING_SLOTS-1:0] r_st_val;
    logic [7:0]               r_st_tag   [PENDING_SLOTS];
    logic [PW-1:0]            r_st_pay   [PENDING_SLOTS];
    logic [2:0]               r_act;
    logic [7:0]               r_tag;
    logic [PW-1:0]            r_data;
    logic                     r_ovalid;
    logic [3:0]               r_ostatus;
    logic [7:0]               r_otag;
    logic [31:0]              r_opay;
    logic [2:0]               r_oslot;

    // Match vectors and first-hit encoders.
    logic [PENDING_SLOTS-1:0] slot_hit, st_hit;
    logic                     slot_any, free_any, st_any, st_free_any;
    logic [SW-1:0]            slot_idx, free_idx, st_idx, st_free_idx;

    always_comb begin
        slot_any = 1'b0; free_any = 1'b0; st_any = 1'b0; st_free_any = 1'b0;
        slot_idx = '0; free_idx = '0; st_idx = '0; st_free_idx = '0;
        for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
            slot_hit[i] = r_slot_act[i] && (r_slot_tag[i] == r_tag);
            st_hit[i]   = r_st_val[i] && (r_st_tag[i] == r_tag);
            if (slot_hit[i]) begin
                slot_any = 1'b1; slot_idx = SW'(i);
            end
            if (!r_slot_act[i]) begin
                free_any = 1'b1; free_idx = SW'(i);
            end
            if (st_hit[i]) begin
                st_any = 1'b1; st_idx = SW'(i);
            end
            if (!r_st_val[i]) begin
                st_free_any = 1'b1; st_free_idx = SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_tag  <= i_tag;
            r_data <= i_result_data[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= trm_pkg::TIMEOUT_RESET;
            r_counter  <= 8'd1;
            r_wait_tag <= '0;
            r_elapsed  <= '0;
            r_slot_act <= '0;
            r_st_val   <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            r_ovalid <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_ostatus <= trm_pkg::ST_IGNORED;
                r_otag    <= r_tag;
                r_opay    <= '0;
                r_oslot   <= '0;
                case (trm_pkg::t_action'(r_act))
                    trm_pkg::ACT_ISSUE: begin
                        r_ostatus <= trm_pkg::ST_ISSUED;
                        r_otag    <= r_counter;
                        r_counter <= (r_counter == trm_pkg::TAG_LAST) ? 8'd1
                                                                      : r_counter + 8'd1;
                    end
                    trm_pkg::ACT_RESPONSE: begin
                        if (r_tag == 8'd0) begin
                            r_ostatus <= trm_pkg::ST_IGNORED;
                        end else if (r_wait_tag == r_tag) begin
                            r_wait_tag <= '0;
                            r_elapsed  <= '0;
                            r_ostatus  <= trm_pkg::ST_RESOLVED;
                            r_opay     <= 32'(r_data);
                        end else if (slot_any) begin
                            r_slot_act[slot_idx] <= 1'b0;
                            r_ostatus <= trm_pkg::ST_FIRED;
                            r_opay    <= 32'(r_data);
                            r_oslot   <= 3'(slot_idx);
                        end else if (st_any) begin
                            r_st_pay[st_idx] <= r_data;
                            r_ostatus        <= trm_pkg::ST_STASHED;
                        end else if (st_free_any) begin
                            r_st_val[st_free_idx] <= 1'b1;
                            r_st_tag[st_free_idx] <= r_tag;
                            r_st_pay[st_free_idx] <= r_data;
                            r_ostatus             <= trm_pkg::ST_STASHED;
                        end else begin
                            // Full: drop entry 0, shift the rest down and append at the end.
                            for (int i = 0; i < PENDING_SLOTS - 1; i++) begin
                                r_st_tag[i] <= r_st_tag[i+1];
                                r_st_pay[i] <= r_st_pay[i+1];
                            end
                            r_st_tag[PENDING_SLOTS-1] <= r_tag;
                            r_st_pay[PENDING_SLOTS-1] <= r_data;
                            r_ostatus <= trm_pkg::ST_STASH_DROP;
                        end
                    end
                    trm_pkg::ACT_REGISTER: begin
                        if (free_any) begin
                            r_slot_act[free_idx] <= 1'b1;
                            r_slot_tag[free_idx] <= r_tag;
                            r_ostatus <= trm_pkg::ST_REGISTERED;
                            r_oslot   <= 3'(free_idx);
                        end else begin
                            r_ostatus <= trm_pkg::ST_NO_SLOT;
                        end
                    end
                    trm_pkg::ACT_CANCEL: begin
                        r_slot_act <= r_slot_act & ~slot_hit;
                        r_ostatus  <= trm_pkg::ST_CANCELLED;
                    end
                    trm_pkg::ACT_WAIT: begin
                        if (st_any) begin
                            r_st_val[st_idx] <= 1'b0;
                            r_ostatus <= trm_pkg::ST_STASH_HIT;
                            r_opay    <= 32'(r_st_pay[st_idx]);
                        end else begin
                            r_wait_tag <= r_tag;
                            r_elapsed  <= '0;
                            r_ostatus  <= trm_pkg::ST_WAITING;
                        end
                    end
                    trm_pkg::ACT_TICK: begin
                        if (r_wait_tag == 8'd0) begin
                            r_ostatus <= trm_pkg::ST_TICK_IDLE;
                            r_otag    <= '0;
                        end else if ({1'b0, r_elapsed} + 17'd1 > {1'b0, r_timeout}) begin
                            r_wait_tag <= '0;
                            r_elapsed  <= '0;
                            r_ostatus  <= trm_pkg::ST_TIMEOUT;
                            r_otag     <= r_wait_tag;
                        end else begin
                            r_elapsed <= r_elapsed + 16'd1;
                            r_ostatus <= trm_pkg::ST_WAITING;
                            r_otag    <= r_wait_tag;
                        end
                    end
                    trm_pkg::ACT_CLEAR: begin
                        r_wait_tag <= '0;
                        r_elapsed  <= '0;
                        r_slot_act <= '0;
                        r_st_val   <= '0;
                        r_ostatus  <= trm_pkg::ST_CLEARED;
                        r_otag     <= '0;
                    end
                    default: begin
                        r_ostatus <= trm_pkg::ST_IGNORED;
                    end
                endcase
            end
        end
    end

    assign o_result_valid = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_tag_out      = r_otag;
    assign o_payload_out  = r_opay;
    assign o_slot_out     = r_oslot;

endmodule
